>>> rtl/min_tracking_stack_top_defines.svh
// Assertion macros for the min-tracking stack top level.
`ifndef MIN_TRACKING_STACK_TOP_DEFINES_SVH
`define MIN_TRACKING_STACK_TOP_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define MTS_CHECK_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define MTS_CHECK_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> rtl/mts_pkg.sv
// Shared types and codes for the min-tracking stack.
package mts_pkg;

    // Operation codes carried by the kind field
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Status codes reported with every result
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_PUSH_FULL  = 2'd1;
    localparam logic [1:0] ST_POP_EMPTY  = 2'd2;

    // Shift control broadcast from the controller to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } shift_ctl_t;

endpackage

>>> rtl/mts_cell.sv
// One stack cell: holds one stored word and shifts with its neighbors.
module mts_cell import mts_pkg::*;
#(
    parameter int WORD_W = 18
)
(
    input  logic              clk,
    input  shift_ctl_t        ctl,
    input  logic [WORD_W-1:0] push_word,
    input  logic [WORD_W-1:0] pop_word,
    output logic [WORD_W-1:0] word
);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    // Take the upper neighbor on push, the lower neighbor on pop, else hold
    always_comb
    begin
        word_next = word_reg;
        if (ctl.push)
        begin
            word_next = push_word;
        end
        else if (ctl.pop)
        begin
            word_next = pop_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

>>> rtl/mts_ctrl.sv
// Controller: fill count, running minimum, word encoding and result registers.
module mts_ctrl import mts_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 16,
    parameter int WORD_W     = DATA_WIDTH + 2
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         kind,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic signed [WORD_W-1:0]     top_word,
    output shift_ctl_t                   ctl,
    output logic [WORD_W-1:0]            new_word,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] popped_value,
    output logic signed [DATA_WIDTH-1:0] current_min,
    output logic                         min_valid,
    output logic [1:0]                   status
);

    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [FILL_W-1:0]           fill_reg;
    logic [FILL_W-1:0]           fill_next;
    logic signed [DATA_WIDTH-1:0] min_reg;
    logic signed [DATA_WIDTH-1:0] min_next;

    logic                         done_reg;
    logic signed [DATA_WIDTH-1:0] popped_reg;
    logic signed [DATA_WIDTH-1:0] popped_next;
    logic signed [DATA_WIDTH-1:0] cur_min_reg;
    logic signed [DATA_WIDTH-1:0] cur_min_next;
    logic                         valid_reg;
    logic                         valid_next;
    logic [1:0]                   status_reg;
    logic [1:0]                   status_next;

    logic                     is_full;
    logic                     is_empty;
    logic signed [WORD_W-1:0] val_ext;
    logic signed [WORD_W-1:0] min_ext;
    logic signed [WORD_W-1:0] enc_word;
    logic signed [WORD_W-1:0] restore_word;
    logic                     top_below;

    assign is_full  = (fill_reg == FILL_W'(DEPTH));
    assign is_empty = (fill_reg == '0);

    // Widen value and minimum to the stored word width
    assign val_ext = {{2{value[DATA_WIDTH-1]}}, value};
    assign min_ext = {{2{min_reg[DATA_WIDTH-1]}}, min_reg};

    // Encode a new minimum as 2*value - min; decode old min as 2*min - word
    assign enc_word     = {val_ext[WORD_W-2:0], 1'b0} - min_ext;
    assign restore_word = {min_ext[WORD_W-2:0], 1'b0} - top_word;
    assign top_below    = (top_word < min_ext);

    // Decode the request and work out the next state and result
    always_comb
    begin
        fill_next   = fill_reg;
        min_next    = min_reg;
        new_word    = val_ext;
        ctl         = '0;
        popped_next = '0;
        status_next = ST_OK;
        case (kind)
            KIND_PUSH:
            begin
                if (is_full)
                begin
                    status_next = ST_PUSH_FULL;
                end
                else
                begin
                    ctl.push  = accept;
                    fill_next = fill_reg + 1'b1;
                    if (is_empty)
                    begin
                        min_next = value;
                    end
                    else if (value < min_reg)
                    begin
                        new_word = enc_word;
                        min_next = value;
                    end
                end
            end
            KIND_POP:
            begin
                if (is_empty)
                begin
                    status_next = ST_POP_EMPTY;
                end
                else
                begin
                    ctl.pop   = accept;
                    fill_next = fill_reg - 1'b1;
                    if (top_below)
                    begin
                        popped_next = min_reg;
                        min_next    = restore_word[DATA_WIDTH-1:0];
                    end
                    else
                    begin
                        popped_next = top_word[DATA_WIDTH-1:0];
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        valid_next   = (fill_next != '0);
        cur_min_next = valid_next ? min_next : '0;
    end

    // Advance control state on an accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            min_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                fill_reg <= fill_next;
                min_reg  <= min_next;
            end
        end
    end

    // Hold the result for its strobe cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg  <= popped_next;
            cur_min_reg <= cur_min_next;
            valid_reg   <= valid_next;
            status_reg  <= status_next;
        end
    end

    assign done         = done_reg;
    assign popped_value = popped_reg;
    assign current_min  = cur_min_reg;
    assign min_valid    = valid_reg;
    assign status       = status_reg;

endmodule

>>> rtl/min_tracking_stack_top.sv
// Top level of the min-tracking stack: controller plus a shifting row of cells.
// A request accepted at a clock edge gives its result, with done high, in the
// following cycle. Throughput: one request per cycle; busy stays low since the
// top entry always sits in the first cell of the shifting row.
// Reset (rst_n low, asynchronous) empties the stack and clears the minimum;
// cell contents are not cleared. The receiver cannot stall results.
`include "min_tracking_stack_top_defines.svh"

module min_tracking_stack_top import mts_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         kind,
    input  logic signed [DATA_WIDTH-1:0] value,
    output logic                         busy,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] popped_value,
    output logic signed [DATA_WIDTH-1:0] current_min,
    output logic                         min_valid,
    output logic [1:0]                   status
);

    localparam int WORD_W = DATA_WIDTH + 2;

    logic              accept;
    shift_ctl_t        ctl;
    logic [WORD_W-1:0] new_word;
    logic [WORD_W-1:0] cell_word [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    mts_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .WORD_W     (WORD_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .kind         (kind),
        .value        (value),
        .top_word     (cell_word[0]),
        .ctl          (ctl),
        .new_word     (new_word),
        .done         (done),
        .popped_value (popped_value),
        .current_min  (current_min),
        .min_valid    (min_valid),
        .status       (status)
    );

    // Build the row: cell 0 is the top of the stack
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_W-1:0] up_word;
        logic [WORD_W-1:0] down_word;

        if (i == 0)
        begin : g_head
            assign up_word = new_word;
        end
        else
        begin : g_body
            assign up_word = cell_word[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign down_word = cell_word[i];
        end
        else
        begin : g_link
            assign down_word = cell_word[i+1];
        end

        mts_cell #(
            .WORD_W (WORD_W)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .push_word (up_word),
            .pop_word  (down_word),
            .word      (cell_word[i])
        );
    end

    // Every accepted request yields a result in the next cycle
    `MTS_CHECK_NEXT(a_result_follows, start && !busy, done, "accepted request gave no result")
    // A refused push means the stack still holds elements
    `MTS_CHECK_NOW(a_full_nonempty, done && status == ST_PUSH_FULL, min_valid, "full push on empty stack")
    // A refused pop leaves an empty stack and a zero popped value
    `MTS_CHECK_NOW(a_empty_pop, done && status == ST_POP_EMPTY, !min_valid && popped_value == '0, "bad empty pop")
    // An empty stack reports a zero minimum
    `MTS_CHECK_NOW(a_empty_min, done && !min_valid, current_min == '0, "nonzero minimum on empty stack")

endmodule

>>> dv/min_tracking_stack_top_test.sv
// Self-checking testbench for the min-tracking stack: scoreboard class and top module.
`timescale 1ns / 1ps

// Predict each result and compare it with what the block returns
class stack_scoreboard #(int DEPTH = 16, int DW = 16);
    typedef logic signed [DW-1:0] data_t;
    typedef logic signed [DW+1:0] word_t;
    typedef struct packed {
        data_t      popped;
        data_t      min_out;
        logic       min_ok;
        logic [1:0] stat;
    } stack_result_t;

    word_t         stack_words[DEPTH];
    int            level;
    data_t         low_mark;
    stack_result_t expected_q[$];

    int mismatches;
    int checked;
    int pushes;
    int pops;
    int refused_full;
    int refused_empty;
    int restores;
    int peak;

    function new();
        level         = 0;
        low_mark      = '0;
        mismatches    = 0;
        checked       = 0;
        pushes        = 0;
        pops          = 0;
        refused_full  = 0;
        refused_empty = 0;
        restores      = 0;
        peak          = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Advance the predicted stack by one accepted request and queue its result
    function void note_request(logic kind, data_t value);
        stack_result_t r;
        word_t         w;
        r      = '0;
        r.stat = mts_pkg::ST_OK;
        if (kind == mts_pkg::KIND_PUSH) begin
            if (level >= DEPTH) begin
                r.stat = mts_pkg::ST_PUSH_FULL;
                refused_full++;
            end
            else begin
                w = word_t'(value);
                if (level == 0)
                    low_mark = value;
                else if (value < low_mark) begin
                    // Encode the old minimum into the stored word
                    w        = 2 * w - word_t'(low_mark);
                    low_mark = value;
                end
                stack_words[level] = w;
                level++;
                pushes++;
                if (level > peak)
                    peak = level;
            end
        end
        else begin
            if (level == 0) begin
                r.stat = mts_pkg::ST_POP_EMPTY;
                refused_empty++;
            end
            else begin
                level--;
                w = stack_words[level];
                pops++;
                if (w < word_t'(low_mark)) begin
                    // Encoded word: hand out the minimum, recover the previous one
                    r.popped = low_mark;
                    low_mark = data_t'(2 * word_t'(low_mark) - w);
                    restores++;
                end
                else
                    r.popped = data_t'(w);
            end
        end
        if (level != 0) begin
            r.min_out = low_mark;
            r.min_ok  = 1'b1;
        end
        expected_q.push_back(r);
    endfunction

    function void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR %t: %s", $realtime, msg);
    endfunction

    // Compare one returned result with the oldest expectation
    function void check_result(data_t popped, data_t min_out, logic min_ok, logic [1:0] stat);
        stack_result_t e;
        if (expected_q.size() == 0) begin
            note_mismatch($sformatf("result with no request pending: popped=%0d min=%0d valid=%b status=%0d",
                                    popped, min_out, min_ok, stat));
            return;
        end
        e = expected_q.pop_front();
        checked++;
        if (popped !== e.popped || min_out !== e.min_out || min_ok !== e.min_ok
            || stat !== e.stat)
            note_mismatch($sformatf({"result %0d: expected popped=%0d min=%0d valid=%b status=%0d,",
                                     " got popped=%0d min=%0d valid=%b status=%0d"},
                                    checked, e.popped, e.min_out, e.min_ok, e.stat,
                                    popped, min_out, min_ok, stat));
    endfunction
endclass

module min_tracking_stack_top_test;
    import mts_pkg::*;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 16;
    localparam int N_ITEMS    = 1200;
    localparam int LIMIT      = 400000;
    localparam logic signed [DATA_WIDTH-1:0] MAX_VAL = 16'sh7fff;
    localparam logic signed [DATA_WIDTH-1:0] MIN_VAL = 16'sh8000;

    typedef stack_scoreboard #(.DEPTH(DEPTH), .DW(DATA_WIDTH)) scoreboard_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         start;
    logic                         kind;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         busy;
    logic                         done;
    logic signed [DATA_WIDTH-1:0] popped_value;
    logic signed [DATA_WIDTH-1:0] current_min;
    logic                         min_valid;
    logic [1:0]                   status;

    scoreboard_t sb = new();

    int cycles = 0;
    int sent = 0;
    int shadow_level = 0;
    int drains = 0;

    min_tracking_stack_top #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .kind         (kind),
        .value        (value),
        .busy         (busy),
        .done         (done),
        .popped_value (popped_value),
        .current_min  (current_min),
        .min_valid    (min_valid),
        .status       (status)
    );

    always #2 clk = ~clk;

    // Note accepted requests and check returned results
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (start && !busy)
                sb.note_request(kind, value);
            if (done)
                sb.check_result(popped_value, current_min, min_valid, status);
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("min_tracking_stack_top: mismatch");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it
    task automatic send(logic k, logic signed [DATA_WIDTH-1:0] v);
        start <= 1'b1;
        kind  <= k;
        value <= v;
        do @(posedge clk); while (busy);
        sent++;
        if (k == KIND_PUSH && shadow_level < DEPTH)
            shadow_level++;
        else if (k == KIND_POP && shadow_level > 0)
            shadow_level--;
    endtask

    // Drop start for a number of cycles
    task automatic pause(int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold off until every pending result has come back
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        drains++;
    endtask

    function automatic int gap_len(bit idle_on);
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mix extremes, values near the current minimum, small values and full-range noise
    function automatic logic signed [DATA_WIDTH-1:0] pick_value();
        int r;
        int t;
        r = $urandom_range(0, 9);
        case (r)
            0: return MIN_VAL;
            1: return MAX_VAL;
            2, 3:
            begin
                t = int'(sb.low_mark) + int'($urandom_range(0, 6)) - 3;
                if (t > 32767)
                    t = 32767;
                if (t < -32768)
                    t = -32768;
                return t[DATA_WIDTH-1:0];
            end
            4, 5: return DATA_WIDTH'(int'($urandom_range(0, 16)) - 8);
            default: return DATA_WIDTH'($urandom());
        endcase
    endfunction

    initial
    begin
        bit   idle_on;
        int   mode;
        int   burst;
        int   push_pct;
        logic k;

        rst_n <= 1'b0;
        start <= 1'b0;
        kind  <= KIND_PUSH;
        value <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pop, first push, equal, below at both extremes, above, unwind
        send(KIND_POP,  16'sh1234);
        send(KIND_PUSH, MAX_VAL);
        send(KIND_PUSH, MAX_VAL);
        send(KIND_PUSH, MIN_VAL);
        send(KIND_PUSH, 16'sd0);
        send(KIND_PUSH, MIN_VAL);
        send(KIND_POP,  16'sd0);
        send(KIND_POP,  16'sd0);
        send(KIND_POP,  16'sd0);
        send(KIND_POP,  16'sd0);
        send(KIND_POP,  16'sd0);
        send(KIND_POP,  16'sd0);
        send(KIND_PUSH, MIN_VAL);
        send(KIND_PUSH, MAX_VAL);
        send(KIND_PUSH, 16'sd5);
        send(KIND_PUSH, -16'sd7);
        send(KIND_POP,  -16'sd1);
        send(KIND_POP,  -16'sd1);
        send(KIND_POP,  -16'sd1);
        send(KIND_POP,  -16'sd1);
        send(KIND_POP,  -16'sd1);
        drain();

        // Random bursts: fill runs to hit full, drain runs to hit empty, mixed traffic
        while (sent < N_ITEMS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            mode    = $urandom_range(0, 9);
            burst   = $urandom_range(4, 40);
            if (mode < 3)
                push_pct = 90;
            else if (mode < 5)
                push_pct = 10;
            else
                push_pct = (shadow_level > DEPTH / 2) ? 40 : 60;
            for (int i = 0; i < burst; i++)
            begin
                k = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
                send(k, pick_value());
                pause(gap_len(idle_on));
            end
            if ($urandom_range(0, 15) == 0)
                drain();
        end

        // Wait out the last results, then let the pipeline settle
        drain();
        repeat (8) @(posedge clk);

        $display("covered %0d requests: %0d pushes, %0d pops, %0d minimum restores, peak fill %0d",
                 sent, sb.pushes, sb.pops, sb.restores, sb.peak);
        $display("refused %0d pushes on full and %0d pops on empty; %0d results checked, %0d bad",
                 sb.refused_full, sb.refused_empty, sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("min_tracking_stack_top: match");
        else
            $display("min_tracking_stack_top: mismatch");
        $finish;
    end
endmodule
